FILE: rtl/core/fst_pkg.sv
package fst_pkg;

  localparam int COORD_BITS      = 16;
  localparam int LIGHT_FRAC_BITS = 16;

  // fixed-point light constants, rounded to nearest
  localparam longint ONE_L = 64'd1 << LIGHT_FRAC_BITS;
  localparam longint W_X   = (3 * ONE_L * 2 + 10) / 20;
  localparam longint W_Y   = (8 * ONE_L * 2 + 10) / 20;
  localparam longint W_Z   = (52 * ONE_L * 2 + 100) / 200;
  localparam longint K_AMB = (55 * ONE_L * 2 + 100) / 200;
  localparam longint K_DIF = (45 * ONE_L * 2 + 100) / 200;

  localparam int EDGE_W   = COORD_BITS + 1;
  localparam int PROD_W   = 2 * EDGE_W;
  localparam int NRM_W    = PROD_W + 1;
  localparam int MAG_W    = PROD_W;
  localparam int POS_W    = $clog2(MAG_W + 2);
  localparam int NORM_W   = 31;                 // largest normalized magnitude lies in [2^30, 2^31)
  localparam int SQP_W    = 2 * NORM_W;
  localparam int SQ_W     = 64;
  localparam int LEN_W    = 32;
  localparam int SQ_STEPS = SQ_W / 2;
  localparam int WP_W     = NORM_W + LIGHT_FRAC_BITS;
  localparam int DS_W     = WP_W + 2;
  localparam int QW       = LIGHT_FRAC_BITS + 2;
  localparam int DIV_W    = (DS_W > LEN_W + QW) ? DS_W : LEN_W + QW;
  localparam int LIGHT_W  = LIGHT_FRAC_BITS + 2;
  localparam int LP_W     = LIGHT_FRAC_BITS + QW;
  localparam int CP_W     = 8 + LIGHT_W;
  localparam int COL_W    = CP_W - LIGHT_FRAC_BITS;

  // stage map: 7 front stages, square root, divider, 3 light/color stages
  localparam int SQ_BASE    = 7;
  localparam int DV_BASE    = SQ_BASE + SQ_STEPS;
  localparam int PIPE_DEPTH = DV_BASE + QW + 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vert_t;

  typedef struct packed {
    vert_t v0;
    vert_t v1;
    vert_t v2;
  } tri_t;

  typedef enum logic [1:0] {
    REG_RED   = 2'd0,
    REG_GREEN = 2'd1,
    REG_BLUE  = 2'd2
  } cfg_reg_t;

endpackage

FILE: rtl/core/flat_shade_triangle.sv
// A taken triangle passes every pipeline stage and the output register before its
// first vertex shows; the second and third vertex follow while out_ready is high.
// A new triangle is taken only when none is held or the held one's last vertex is taken.
// The 32-step square root and 18-step divider are fully pipelined, one step per stage.
// Reset (rst, synchronous): pipeline empties, base colors return to 255.
module flat_shade_triangle (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [fst_pkg::COORD_BITS-1:0] first_x,
  input  logic signed [fst_pkg::COORD_BITS-1:0] first_y,
  input  logic signed [fst_pkg::COORD_BITS-1:0] first_z,
  input  logic signed [fst_pkg::COORD_BITS-1:0] second_x,
  input  logic signed [fst_pkg::COORD_BITS-1:0] second_y,
  input  logic signed [fst_pkg::COORD_BITS-1:0] second_z,
  input  logic signed [fst_pkg::COORD_BITS-1:0] third_x,
  input  logic signed [fst_pkg::COORD_BITS-1:0] third_y,
  input  logic signed [fst_pkg::COORD_BITS-1:0] third_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [fst_pkg::COORD_BITS-1:0] pos_x,
  output logic signed [fst_pkg::COORD_BITS-1:0] pos_y,
  output logic signed [fst_pkg::COORD_BITS-1:0] pos_z,
  output logic [7:0]                        shade_red,
  output logic [7:0]                        shade_green,
  output logic [7:0]                        shade_blue,
  output logic                              last_vertex,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [7:0]                        cfg_data
);

  localparam int L = fst_pkg::LIGHT_FRAC_BITS;
  localparam logic [L-1:0] WX   = L'(fst_pkg::W_X);
  localparam logic [L-1:0] WY   = L'(fst_pkg::W_Y);
  localparam logic [L-1:0] WZ   = L'(fst_pkg::W_Z);
  localparam logic [L-1:0] KAMB = L'(fst_pkg::K_AMB);
  localparam logic [L-1:0] KDIF = L'(fst_pkg::K_DIF);

  // ---------------- configuration
  logic [7:0] base_red, base_green, base_blue;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_red   <= 8'd255;
      base_green <= 8'd255;
      base_blue  <= 8'd255;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fst_pkg::REG_RED:   base_red   <= cfg_data;
        fst_pkg::REG_GREEN: base_green <= cfg_data;
        fst_pkg::REG_BLUE:  base_blue  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control
  logic                  en;
  logic                  vld     [fst_pkg::PIPE_DEPTH];
  fst_pkg::tri_t         tri_q   [fst_pkg::PIPE_DEPTH];
  fst_pkg::tri_t         tri_in;

  logic                  ser_vld;
  fst_pkg::tri_t         ser_tri;
  logic [7:0]            ser_r, ser_g, ser_b;
  logic [1:0]            cnt;

  // whole pipe moves together; it holds only while a triangle still has vertices to send
  assign en       = !ser_vld || (out_ready && cnt == 2'd2);
  assign in_ready = en;

  assign tri_in = '{v0: '{first_x, first_y, first_z},
                    v1: '{second_x, second_y, second_z},
                    v2: '{third_x, third_y, third_z}};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < fst_pkg::PIPE_DEPTH; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < fst_pkg::PIPE_DEPTH; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tri_q[0] <= tri_in;
      for (int k = 1; k < fst_pkg::PIPE_DEPTH; k++) tri_q[k] <= tri_q[k-1];
    end
  end

  // ---------------- stage 0: edges
  logic signed [fst_pkg::EDGE_W-1:0] ux, uy, uz, vx, vy, vz;

  always_ff @(posedge clk) begin
    if (en) begin
      ux <= fst_pkg::EDGE_W'(second_x) - fst_pkg::EDGE_W'(first_x);
      uy <= fst_pkg::EDGE_W'(second_y) - fst_pkg::EDGE_W'(first_y);
      uz <= fst_pkg::EDGE_W'(second_z) - fst_pkg::EDGE_W'(first_z);
      vx <= fst_pkg::EDGE_W'(third_x) - fst_pkg::EDGE_W'(first_x);
      vy <= fst_pkg::EDGE_W'(third_y) - fst_pkg::EDGE_W'(first_y);
      vz <= fst_pkg::EDGE_W'(third_z) - fst_pkg::EDGE_W'(first_z);
    end
  end

  // ---------------- stage 1: cross product terms
  logic signed [fst_pkg::PROD_W-1:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;

  always_ff @(posedge clk) begin
    if (en) begin
      p_yz <= uy * vz;
      p_zy <= uz * vy;
      p_zx <= uz * vx;
      p_xz <= ux * vz;
      p_xy <= ux * vy;
      p_yx <= uy * vx;
    end
  end

  // ---------------- stage 2: normal, sign and magnitude
  logic signed [fst_pkg::NRM_W-1:0] n0, n1, n2;
  logic [fst_pkg::MAG_W-1:0]        mg0, mg1, mg2;
  logic                             ng0, ng1, ng2;

  always_comb begin
    n0 = fst_pkg::NRM_W'(p_yz) - fst_pkg::NRM_W'(p_zy);
    n1 = fst_pkg::NRM_W'(p_zx) - fst_pkg::NRM_W'(p_xz);
    n2 = fst_pkg::NRM_W'(p_xy) - fst_pkg::NRM_W'(p_yx);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ng0 <= n0 < 0;
      ng1 <= n1 < 0;
      ng2 <= n2 < 0;
      mg0 <= fst_pkg::MAG_W'((n0 < 0) ? -n0 : n0);
      mg1 <= fst_pkg::MAG_W'((n1 < 0) ? -n1 : n1);
      mg2 <= fst_pkg::MAG_W'((n2 < 0) ? -n2 : n2);
    end
  end

  // ---------------- stage 3: leading one of the largest magnitude
  logic [fst_pkg::MAG_W-1:0] or_all;
  logic [fst_pkg::POS_W-1:0] pos_next;
  logic [fst_pkg::MAG_W-1:0] mh0, mh1, mh2;
  logic                      nh0, nh1, nh2;
  logic [fst_pkg::POS_W-1:0] lead;
  logic                      zero3;

  always_comb begin
    or_all   = mg0 | mg1 | mg2;
    pos_next = '0;
    for (int i = 0; i < fst_pkg::MAG_W; i++) begin
      if (or_all[i]) pos_next = fst_pkg::POS_W'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mh0   <= mg0;
      mh1   <= mg1;
      mh2   <= mg2;
      nh0   <= ng0;
      nh1   <= ng1;
      nh2   <= ng2;
      lead  <= pos_next;
      zero3 <= or_all == '0;
    end
  end

  // ---------------- stage 4: normalize so the largest lies in [2^30, 2^31)
  logic [fst_pkg::MAG_W+fst_pkg::NORM_W-1:0] wide0, wide1, wide2;
  logic [fst_pkg::NORM_W-1:0] m0, m1, m2;
  logic                       nn0, nn1, nn2;
  logic                       zero4;

  always_comb begin
    wide0 = {mh0, fst_pkg::NORM_W'(0)} >> lead;
    wide1 = {mh1, fst_pkg::NORM_W'(0)} >> lead;
    wide2 = {mh2, fst_pkg::NORM_W'(0)} >> lead;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0    <= wide0[fst_pkg::NORM_W-1:0];
      m1    <= wide1[fst_pkg::NORM_W-1:0];
      m2    <= wide2[fst_pkg::NORM_W-1:0];
      nn0   <= nh0;
      nn1   <= nh1;
      nn2   <= nh2;
      zero4 <= zero3;
    end
  end

  // ---------------- stage 5: squares and weighted terms
  logic [fst_pkg::SQP_W-1:0] sqp0, sqp1, sqp2;
  logic [fst_pkg::WP_W-1:0]  wp0, wp1, wp2;
  logic                      nw0, nw1, nw2;
  logic                      zero5;

  always_ff @(posedge clk) begin
    if (en) begin
      sqp0  <= m0 * m0;
      sqp1  <= m1 * m1;
      sqp2  <= m2 * m2;
      wp0   <= m0 * WX;
      wp1   <= m1 * WY;
      wp2   <= m2 * WZ;
      nw0   <= nn0;
      nw1   <= nn1;
      nw2   <= nn2;
      zero5 <= zero4;
    end
  end

  // ---------------- stage 6: sum of squares, dot product
  logic signed [fst_pkg::DS_W-1:0] t0, t1, t2, dsum;
  logic [fst_pkg::SQ_W-1:0]        sq;
  logic [fst_pkg::DS_W-2:0]        dmag;
  logic                            dpos;

  always_comb begin
    t0   = nw0 ? -$signed({2'b00, wp0}) : $signed({2'b00, wp0});
    t1   = nw1 ? -$signed({2'b00, wp1}) : $signed({2'b00, wp1});
    t2   = nw2 ? -$signed({2'b00, wp2}) : $signed({2'b00, wp2});
    dsum = t0 + t1 + t2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq   <= fst_pkg::SQ_W'(sqp0) + fst_pkg::SQ_W'(sqp1) + fst_pkg::SQ_W'(sqp2);
      dmag <= dsum[fst_pkg::DS_W-2:0];
      dpos <= !zero5 && (dsum > 0);
    end
  end

  // ---------------- integer square root, one result bit per stage
  logic [fst_pkg::SQ_W-1:0] sx [fst_pkg::SQ_STEPS];
  logic [fst_pkg::SQ_W-1:0] sr [fst_pkg::SQ_STEPS];
  logic [fst_pkg::DS_W-2:0] sd [fst_pkg::SQ_STEPS];
  logic                     sp [fst_pkg::SQ_STEPS];
  logic [fst_pkg::SQ_W-1:0] sx_next [fst_pkg::SQ_STEPS];
  logic [fst_pkg::SQ_W-1:0] sr_next [fst_pkg::SQ_STEPS];

  always_comb begin
    logic [fst_pkg::SQ_W-1:0] xi, ri, bt;
    for (int i = 0; i < fst_pkg::SQ_STEPS; i++) begin
      xi = (i == 0) ? sq : sx[(i == 0) ? 0 : i-1];
      ri = (i == 0) ? '0 : sr[(i == 0) ? 0 : i-1];
      bt = fst_pkg::SQ_W'(1) << (fst_pkg::SQ_W - 2 - 2 * i);
      if (xi >= ri + bt) begin
        sx_next[i] = xi - (ri + bt);
        sr_next[i] = (ri >> 1) + bt;
      end else begin
        sx_next[i] = xi;
        sr_next[i] = ri >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < fst_pkg::SQ_STEPS; i++) begin
        sx[i] <= sx_next[i];
        sr[i] <= sr_next[i];
        sd[i] <= (i == 0) ? dmag : sd[(i == 0) ? 0 : i-1];
        sp[i] <= (i == 0) ? dpos : sp[(i == 0) ? 0 : i-1];
      end
    end
  end

  // ---------------- restoring divider, one quotient bit per stage
  logic [fst_pkg::DIV_W-1:0] dr   [fst_pkg::QW];
  logic [fst_pkg::QW-1:0]    dq   [fst_pkg::QW];
  logic [fst_pkg::LEN_W-1:0] dl   [fst_pkg::QW];
  logic                      dp   [fst_pkg::QW];
  logic [fst_pkg::DIV_W-1:0] dr_next [fst_pkg::QW];
  logic [fst_pkg::QW-1:0]    dq_next [fst_pkg::QW];
  logic [fst_pkg::LEN_W-1:0] dl_in   [fst_pkg::QW];
  logic                      dp_in   [fst_pkg::QW];

  always_comb begin
    logic [fst_pkg::DIV_W-1:0] ri, trial;
    logic [fst_pkg::QW-1:0]    qi;
    for (int j = 0; j < fst_pkg::QW; j++) begin
      if (j == 0) begin
        ri       = fst_pkg::DIV_W'(sd[fst_pkg::SQ_STEPS-1]);
        qi       = '0;
        dl_in[j] = sr[fst_pkg::SQ_STEPS-1][fst_pkg::LEN_W-1:0];
        dp_in[j] = sp[fst_pkg::SQ_STEPS-1];
      end else begin
        ri       = dr[(j == 0) ? 0 : j-1];
        qi       = dq[(j == 0) ? 0 : j-1];
        dl_in[j] = dl[(j == 0) ? 0 : j-1];
        dp_in[j] = dp[(j == 0) ? 0 : j-1];
      end
      trial = fst_pkg::DIV_W'(dl_in[j]) << (fst_pkg::QW - 1 - j);
      if (ri >= trial) begin
        dr_next[j] = ri - trial;
        dq_next[j] = qi | (fst_pkg::QW'(1) << (fst_pkg::QW - 1 - j));
      end else begin
        dr_next[j] = ri;
        dq_next[j] = qi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < fst_pkg::QW; j++) begin
        dr[j] <= dr_next[j];
        dq[j] <= dq_next[j];
        dl[j] <= dl_in[j];
        dp[j] <= dp_in[j];
      end
    end
  end

  // ---------------- light and color
  logic [fst_pkg::QW-1:0]      cq;
  logic [fst_pkg::LP_W-1:0]    lp;
  logic [fst_pkg::LIGHT_W-1:0] light;
  logic [fst_pkg::CP_W-1:0]    cp_r, cp_g, cp_b;

  assign cq = dp[fst_pkg::QW-1] ? dq[fst_pkg::QW-1] : '0;

  always_ff @(posedge clk) begin
    if (en) begin
      lp    <= KDIF * cq;
      light <= fst_pkg::LIGHT_W'(KAMB) + fst_pkg::LIGHT_W'(lp >> L);
      cp_r  <= base_red * light;
      cp_g  <= base_green * light;
      cp_b  <= base_blue * light;
    end
  end

  function automatic logic [7:0] clamp8(input logic [fst_pkg::CP_W-1:0] p);
    logic [fst_pkg::COL_W-1:0] c;
    c = p[fst_pkg::CP_W-1:L];
    return (c > fst_pkg::COL_W'(255)) ? 8'd255 : c[7:0];
  endfunction

  // ---------------- output: one triangle held, three vertices sent
  always_ff @(posedge clk) begin
    if (rst) begin
      ser_vld <= 1'b0;
      cnt     <= 2'd0;
    end else if (en) begin
      ser_vld <= vld[fst_pkg::PIPE_DEPTH-1];
      cnt     <= 2'd0;
    end else if (out_ready) begin
      cnt <= cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ser_tri <= tri_q[fst_pkg::PIPE_DEPTH-1];
      ser_r   <= clamp8(cp_r);
      ser_g   <= clamp8(cp_g);
      ser_b   <= clamp8(cp_b);
    end
  end

  fst_pkg::vert_t cur;

  always_comb begin
    if (cnt == 2'd0)      cur = ser_tri.v0;
    else if (cnt == 2'd1) cur = ser_tri.v1;
    else                  cur = ser_tri.v2;
  end

  assign out_valid   = ser_vld;
  assign pos_x       = cur.x;
  assign pos_y       = cur.y;
  assign pos_z       = cur.z;
  assign shade_red   = ser_r;
  assign shade_green = ser_g;
  assign shade_blue  = ser_b;
  assign last_vertex = cnt == 2'd2;

  // ---------------- checks
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3)
    else $error("vertex counter out of range");

  a_no_take_mid: assert property (@(posedge clk) disable iff (rst)
    (ser_vld && cnt != 2'd2) |-> !in_ready)
    else $error("input taken while a triangle is half sent");

  a_vertices_follow: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_vertex) |=> out_valid)
    else $error("triangle dropped before its last vertex");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vld[0])
    else $error("accepted item not in first stage");

endmodule
